// ----- src/twd_pkg.sv -----
package twd_pkg;

   // per-track table
   localparam int TRACK_SLOTS = 1024;
   localparam int SLOT_W      = $clog2(TRACK_SLOTS);

   // field widths
   localparam int ID_W    = 10;
   localparam int X_W     = 11;
   localparam int Y_W     = 10;
   localparam int SCORE_W = 16;

   // doubled centres and history count
   localparam int X2_W   = 12;
   localparam int Y2_W   = 11;
   localparam int SEEN_W = 2;
   localparam logic [SEEN_W-1:0] SEEN_MAX = 2'd2;

   // edge band on doubled centres (30 px from left/top, 1250 / 690 px limits)
   localparam logic [X2_W-1:0] EDGE_LO_X2 = 12'd60;
   localparam logic [Y2_W-1:0] EDGE_LO_Y2 = 11'd60;
   localparam logic [X2_W-1:0] EDGE_HI_X2 = 12'd2500;
   localparam logic [Y2_W-1:0] EDGE_HI_Y2 = 11'd1380;

   // line arithmetic
   localparam int DX_W   = X_W + 1;
   localparam int DY_W   = Y_W + 1;
   localparam int PROD_W = DX_W + DY_W;

   // input queue and result queue
   localparam int Q_DEPTH     = 4;
   localparam int Q_PTR_W     = $clog2(Q_DEPTH);
   localparam int Q_CNT_W     = Q_PTR_W + 1;
   localparam int OUT_DEPTH   = 4;
   localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W   = OUT_PTR_W + 1;
   localparam int OUT_SUM_W   = OUT_CNT_W + 1;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_START_X = 3'd0,
      CSR_LINE_START_Y = 3'd1,
      CSR_LINE_END_X   = 3'd2,
      CSR_LINE_END_Y   = 3'd3,
      CSR_VERTICAL     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [ID_W-1:0]    track_id;
      logic [X_W-1:0]     box_left;
      logic [Y_W-1:0]     box_top;
      logic [X_W-1:0]     box_right;
      logic [Y_W-1:0]     box_bottom;
      logic [SCORE_W-1:0] score;
      logic               track_lost;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]    flagged_track;
      logic [X_W-1:0]     out_left;
      logic [Y_W-1:0]     out_top;
      logic [X_W-1:0]     out_right;
      logic [Y_W-1:0]     out_bottom;
      logic [SCORE_W-1:0] out_score;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [X2_W-1:0]   cx2;
      logic [Y2_W-1:0]   cy2;
      logic              new_edge;
      rsp_type           rsp;
   } item_type;

   // one entry of the centre table
   typedef struct packed {
      logic [X2_W-1:0]   x2;
      logic [Y2_W-1:0]   y2;
      logic [SEEN_W-1:0] seen;
   } centre_type;

   typedef struct packed {
      logic [X_W-1:0]  line_start_x;
      logic [Y_W-1:0]  line_start_y;
      logic [DX_W-1:0] dx;
      logic [DY_W-1:0] dy;
      logic            dx_zero;
      logic            dy_zero;
      logic [Y_W-1:0]  mid;
      logic            vertical;
   } cfg_type;

   typedef struct packed {
      logic                 clearing;
      logic                 head_pop;
      logic                 out_push;
      logic [OUT_CNT_W-1:0] out_count;
   } back_status_type;

   function automatic logic near_edge(input logic [X2_W-1:0] x2, input logic [Y2_W-1:0] y2);
      near_edge = (x2 < EDGE_LO_X2) || (x2 > EDGE_HI_X2) ||
                  (y2 < EDGE_LO_Y2) || (y2 > EDGE_HI_Y2);
   endfunction

endpackage

// ----- src/twd_ram.sv -----
module twd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- src/twd_front.sv -----
module twd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  twd_pkg::req_type  req_data,
   input  logic              clearing,
   input  logic              head_pop,
   output logic              head_valid,
   output twd_pkg::item_type head
);
   import twd_pkg::*;

   item_type           queue_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               accept, enq, deq;
   item_type           item;

   // classify: slot, doubled centre, edge check, payload for the result
   always_comb begin
      item.slot              = SLOT_W'(req_data.track_id);
      item.cx2               = X2_W'(req_data.box_left) + X2_W'(req_data.box_right);
      item.cy2               = Y2_W'(req_data.box_top) + Y2_W'(req_data.box_bottom);
      item.new_edge          = near_edge(item.cx2, item.cy2);
      item.rsp.flagged_track = req_data.track_id;
      item.rsp.out_left      = req_data.box_left;
      item.rsp.out_top       = req_data.box_top;
      item.rsp.out_right     = req_data.box_right;
      item.rsp.out_bottom    = req_data.box_bottom;
      item.rsp.out_score     = req_data.score;
   end

   always_comb begin
      full       = (count_ff == Q_CNT_W'(Q_DEPTH)) || clearing;
      accept     = push && !full;
      // drop lost tracks here: no state change, no result
      enq        = accept && !req_data.track_lost;
      head_valid = count_ff != '0;
      deq        = head_pop && head_valid;
      head       = queue_ff[rd_ptr_ff];
      wr_ptr_in  = enq ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = deq ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in   = count_ff + Q_CNT_W'(enq) - Q_CNT_W'(deq);
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/twd_back.sv -----
module twd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  twd_pkg::cfg_type         cfg,
   input  logic                     head_valid,
   input  twd_pkg::item_type        head,
   output logic                     head_pop,
   output twd_pkg::back_status_type status,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output twd_pkg::rsp_type         rsp_data
);
   import twd_pkg::*;

   typedef struct packed {
      logic              pair_ok;
      logic              vert_hit;
      logic              up;
      logic              flat;
      logic [PROD_W-1:0] lhs;
      logic [PROD_W-1:0] rhs;
      logic [SLOT_W-1:0] slot;
      rsp_type           rsp;
   } stage2_type;

   // clearing pass
   logic              clr_active_ff, clr_active_in;
   logic [SLOT_W-1:0] clr_addr_ff, clr_addr_in;

   // pipeline
   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_ff;
   logic       s2_valid_ff, s2_valid_in;
   stage2_type s2_ff, s2_in;

   // centre table
   centre_type        crd_data, cur, c_wr_data;
   logic              c_wr_en;
   logic [SLOT_W-1:0] c_wr_addr;
   logic              cfw_valid_ff;
   logic [SLOT_W-1:0] cfw_slot_ff;
   centre_type        cfw_data_ff;

   // wrong-way flag table
   logic              wrd_data, w_cur, w_wr_en, w_wr_data;
   logic [SLOT_W-1:0] w_wr_addr;
   logic              wfw_valid_ff;
   logic [SLOT_W-1:0] wfw_slot_ff;
   logic              wfw_data_ff;

   // stage 1 arithmetic
   logic                   had_prev, old_edge;
   logic [X_W-1:0]         ox, nx;
   logic [Y_W-1:0]         oy, ny;
   logic signed [DX_W-1:0] ox_rel;
   logic signed [DY_W-1:0] oy_rel;
   logic signed [PROD_W-1:0] lhs, rhs;
   logic [SEEN_W-1:0]      seen_next;

   // stage 2 decision
   logic signed [PROD_W:0] diff;
   logic                   line_hit, hit, emit, set_flag;

   // result queue
   rsp_type              out_q_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] out_wr_ff, out_wr_in, out_rd_ff, out_rd_in;
   logic [OUT_CNT_W-1:0] out_count_ff, out_count_in;
   logic [OUT_SUM_W-1:0] committed;
   logic                 out_pop;

   // issue: keep room in the result queue for every item in flight
   always_comb begin
      committed = OUT_SUM_W'(out_count_ff) + OUT_SUM_W'(s1_valid_ff) +
                  OUT_SUM_W'(s2_valid_ff);
      head_pop  = head_valid && !clr_active_ff && (committed < OUT_SUM_W'(OUT_DEPTH));
      s1_valid_in = head_pop;
   end

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + SLOT_W'(1);
         if (clr_addr_ff == SLOT_W'(TRACK_SLOTS - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   twd_ram #(
      .WIDTH ($bits(centre_type)),
      .DEPTH (TRACK_SLOTS)
   ) u_centre_ram (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (c_wr_data),
      .rd_addr (head.slot),
      .rd_data (crd_data)
   );

   twd_ram #(
      .WIDTH (1),
      .DEPTH (TRACK_SLOTS)
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (w_wr_addr),
      .wr_data (w_wr_data),
      .rd_addr (s1_ff.slot),
      .rd_data (wrd_data)
   );

   // stage 1: centre read-modify-write, pair checks, products
   always_comb begin
      // take the write made at the last edge, the table read missed it
      cur = (cfw_valid_ff && cfw_slot_ff == s1_ff.slot) ? cfw_data_ff : crd_data;
      had_prev  = cur.seen != '0;
      old_edge  = near_edge(cur.x2, cur.y2);
      seen_next = (cur.seen < SEEN_MAX) ? cur.seen + SEEN_W'(1) : cur.seen;

      ox = cur.x2[X2_W-1:1];
      oy = cur.y2[Y2_W-1:1];
      nx = s1_ff.cx2[X2_W-1:1];
      ny = s1_ff.cy2[Y2_W-1:1];

      ox_rel = $signed({1'b0, ox}) - $signed({1'b0, cfg.line_start_x});
      oy_rel = $signed({1'b0, oy}) - $signed({1'b0, cfg.line_start_y});
      lhs    = PROD_W'($signed(cfg.dy)) * PROD_W'(ox_rel);
      rhs    = PROD_W'(oy_rel) * PROD_W'($signed(cfg.dx));

      s2_in.pair_ok  = had_prev && !old_edge && !s1_ff.new_edge;
      s2_in.vert_hit = (ox > nx) ? (cfg.mid < oy) : (cfg.mid > oy);
      s2_in.up       = oy > ny;
      s2_in.flat     = oy == ny;
      s2_in.lhs      = lhs;
      s2_in.rhs      = rhs;
      s2_in.slot     = s1_ff.slot;
      s2_in.rsp      = s1_ff.rsp;
      s2_valid_in    = s1_valid_ff;

      if (clr_active_ff) begin
         c_wr_en   = 1'b1;
         c_wr_addr = clr_addr_ff;
         c_wr_data = '0;
      end else begin
         c_wr_en        = s1_valid_ff;
         c_wr_addr      = s1_ff.slot;
         c_wr_data.x2   = s1_ff.cx2;
         c_wr_data.y2   = s1_ff.cy2;
         c_wr_data.seen = seen_next;
      end
   end

   // stage 2: side of line, wrong-way flag read-modify-write
   always_comb begin
      diff = $signed({s2_ff.lhs[PROD_W-1], s2_ff.lhs}) -
             $signed({s2_ff.rhs[PROD_W-1], s2_ff.rhs});
      // hit when sign(diff) * sign(dy) is negative moving up, positive moving down
      line_hit = !cfg.dx_zero && !cfg.dy_zero && !s2_ff.flat && (diff != '0) &&
                 ((diff[PROD_W] ^ cfg.dy[DY_W-1]) == s2_ff.up);
      w_cur = (wfw_valid_ff && wfw_slot_ff == s2_ff.slot) ? wfw_data_ff : wrd_data;

      hit      = 1'b0;
      emit     = 1'b0;
      set_flag = 1'b0;
      if (cfg.vertical) begin
         emit = s2_valid_ff && s2_ff.pair_ok && s2_ff.vert_hit;
      end else begin
         hit      = s2_valid_ff && s2_ff.pair_ok && line_hit;
         emit     = hit && w_cur;
         set_flag = hit && !w_cur;
      end

      if (clr_active_ff) begin
         w_wr_en   = 1'b1;
         w_wr_addr = clr_addr_ff;
         w_wr_data = 1'b0;
      end else begin
         w_wr_en   = set_flag;
         w_wr_addr = s2_ff.slot;
         w_wr_data = 1'b1;
      end
   end

   // result queue
   always_comb begin
      rsp_empty    = out_count_ff == '0;
      rsp_data     = out_q_ff[out_rd_ff];
      out_pop      = rsp_pop && !rsp_empty;
      out_wr_in    = emit ? out_wr_ff + OUT_PTR_W'(1) : out_wr_ff;
      out_rd_in    = out_pop ? out_rd_ff + OUT_PTR_W'(1) : out_rd_ff;
      out_count_in = out_count_ff + OUT_CNT_W'(emit) - OUT_CNT_W'(out_pop);

      status.clearing  = clr_active_ff;
      status.head_pop  = head_pop;
      status.out_push  = emit;
      status.out_count = out_count_ff;
   end

   always_ff @(posedge clock) begin
      s1_ff       <= head;
      s2_ff       <= s2_in;
      cfw_slot_ff <= c_wr_addr;
      cfw_data_ff <= c_wr_data;
      wfw_slot_ff <= w_wr_addr;
      wfw_data_ff <= w_wr_data;
      if (emit) begin
         out_q_ff[out_wr_ff] <= s2_ff.rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         cfw_valid_ff  <= 1'b0;
         wfw_valid_ff  <= 1'b0;
         out_wr_ff     <= '0;
         out_rd_ff     <= '0;
         out_count_ff  <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         cfw_valid_ff  <= c_wr_en;
         wfw_valid_ff  <= w_wr_en;
         out_wr_ff     <= out_wr_in;
         out_rd_ff     <= out_rd_in;
         out_count_ff  <= out_count_in;
      end
   end

endmodule

// ----- src/track_wrong_way_detector.sv -----
// Wrong-way vehicle detector. Push one tracked detection per transaction on the
// req side; a box judged to move the wrong way against the configured dividing line
// (or, in vertical mode, against the midpoint of the line's y ends) comes out as one
// transaction on the rsp side, and most detections produce none. The block takes one
// detection every clock cycle while full is low; the per-track table of last centre,
// history count and wrong-way flag is read once per detection and rewritten in a
// two-stage back end with forwarding, the flag only on a first hit, so repeated hits
// on the same track need no spacing. Results pass from the input queue via stage 1
// and stage 2 into the result queue. After reset the block clears all TRACK_SLOTS
// (1024) track table entries, full high meanwhile; configuration writes are taken
// at any time but should only be made while the block is idle.
module track_wrong_way_detector (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  twd_pkg::req_type                    req_data,
   output logic                                empty,
   input  logic                                pop,
   output twd_pkg::rsp_type                    rsp_data,
   input  logic                                csr_wr_en,
   input  logic [twd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [twd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import twd_pkg::*;

   logic [X_W-1:0]  line_start_x_ff, line_end_x_ff;
   logic [Y_W-1:0]  line_start_y_ff, line_end_y_ff;
   logic            vertical_ff;
   logic [Y_W:0]    mid_sum;
   cfg_type         cfg;

   logic            head_valid, head_pop;
   item_type        head;
   back_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_start_x_ff <= X_W'(1);
         line_start_y_ff <= '0;
         line_end_x_ff   <= '0;
         line_end_y_ff   <= '0;
         vertical_ff     <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LINE_START_X: line_start_x_ff <= csr_wdata[X_W-1:0];
            CSR_LINE_START_Y: line_start_y_ff <= csr_wdata[Y_W-1:0];
            CSR_LINE_END_X:   line_end_x_ff   <= csr_wdata[X_W-1:0];
            CSR_LINE_END_Y:   line_end_y_ff   <= csr_wdata[Y_W-1:0];
            CSR_VERTICAL:     vertical_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      mid_sum          = {1'b0, line_start_y_ff} + {1'b0, line_end_y_ff};
      cfg.line_start_x = line_start_x_ff;
      cfg.line_start_y = line_start_y_ff;
      cfg.dx           = {1'b0, line_start_x_ff} - {1'b0, line_end_x_ff};
      cfg.dy           = {1'b0, line_start_y_ff} - {1'b0, line_end_y_ff};
      cfg.dx_zero      = line_start_x_ff == line_end_x_ff;
      cfg.dy_zero      = line_start_y_ff == line_end_y_ff;
      cfg.mid          = mid_sum[Y_W:1];
      cfg.vertical     = vertical_ff;
   end

   twd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .clearing   (status.clearing),
      .head_pop   (head_pop),
      .head_valid (head_valid),
      .head       (head)
   );

   twd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .status     (status),
      .rsp_empty  (empty),
      .rsp_pop    (pop),
      .rsp_data   (rsp_data)
   );

   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> status.clearing)
      else $error("table clearing pass did not start after reset");

   a_no_issue_while_clearing: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !status.head_pop && !status.out_push && empty)
      else $error("detection in flight while the track table is being cleared");

   a_no_result_overflow: assert property (@(posedge clock) disable iff (reset)
      status.out_push |-> status.out_count != OUT_CNT_W'(OUT_DEPTH))
      else $error("result pushed into a full result queue");

endmodule

// ----- tb/tb_track_wrong_way_detector.sv -----
`timescale 1ns / 1ps

module tb_track_wrong_way_detector;
   import twd_pkg::*;

   localparam int SLOTS          = 1024;
   localparam int MARGIN2        = 60;
   localparam int X_LIMIT2       = 2500;
   localparam int Y_LIMIT2       = 1380;
   localparam int SETTLE_CYCLES  = 16;
   localparam int PRINT_CAP      = 50;
   localparam int TRAJECTORIES   = 16;

   class wrong_way_scoreboard;
      logic [X_W-1:0] line_start_x;
      logic [Y_W-1:0] line_start_y;
      logic [X_W-1:0] line_end_x;
      logic [Y_W-1:0] line_end_y;
      logic           vertical;

      logic [11:0] centre_x2 [SLOTS];
      logic [10:0] centre_y2 [SLOTS];
      logic [1:0]  seen_count [SLOTS];
      bit          wrong_way [SLOTS];

      rsp_type pending_flags [$];
      int      mismatch_count;

      function new();
         line_start_x = 1;
         line_start_y = 0;
         line_end_x = 0;
         line_end_y = 0;
         vertical = 0;
         foreach (centre_x2[i]) begin
            centre_x2[i] = '0;
            centre_y2[i] = '0;
            seen_count[i] = '0;
            wrong_way[i] = 0;
         end
         mismatch_count = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_LINE_START_X: line_start_x = value[X_W-1:0];
            CSR_LINE_START_Y: line_start_y = value[Y_W-1:0];
            CSR_LINE_END_X:   line_end_x = value[X_W-1:0];
            CSR_LINE_END_Y:   line_end_y = value[Y_W-1:0];
            CSR_VERTICAL:     vertical = value[0];
            default: ;
         endcase
      endfunction

      function int sign_of(int v);
         if (v > 0) return 1;
         if (v < 0) return -1;
         return 0;
      endfunction

      function bit off_frame(logic [11:0] x2, logic [10:0] y2);
         return x2 < MARGIN2 || x2 > X_LIMIT2 || y2 < MARGIN2 || y2 > Y_LIMIT2;
      endfunction

      // side of the line at the older x, by cross multiplication, against the motion
      function bit against_line(int ox, int oy, int ny);
         int dx, dy, side, slope;
         dx = int'(line_start_x) - int'(line_end_x);
         dy = int'(line_start_y) - int'(line_end_y);
         if (dx == 0 || dy == 0 || oy == ny) return 0;
         side = sign_of(dy * (ox - int'(line_start_x)) - (oy - int'(line_start_y)) * dx)
                * sign_of(dx);
         slope = sign_of(dy) * sign_of(dx);
         if (side == 0) return 0;
         if (oy > ny) return side * slope < 0;
         return side * slope > 0;
      endfunction

      function void note_detection(req_type d);
         logic [11:0] old_x2, new_x2;
         logic [10:0] old_y2, new_y2;
         logic        had_prev, emit;
         int          ox, oy, nx, ny, mid;
         rsp_type     r;
         if (d.track_lost) return;
         new_x2 = 12'(d.box_left) + 12'(d.box_right);
         new_y2 = 11'(d.box_top) + 11'(d.box_bottom);
         old_x2 = centre_x2[d.track_id];
         old_y2 = centre_y2[d.track_id];
         had_prev = seen_count[d.track_id] != 0;
         centre_x2[d.track_id] = new_x2;
         centre_y2[d.track_id] = new_y2;
         if (seen_count[d.track_id] < 2) seen_count[d.track_id]++;
         if (!had_prev || off_frame(old_x2, old_y2) || off_frame(new_x2, new_y2)) return;
         ox = int'(old_x2 >> 1);
         oy = int'(old_y2 >> 1);
         nx = int'(new_x2 >> 1);
         ny = int'(new_y2 >> 1);
         emit = 0;
         if (vertical) begin
            mid = (int'(line_start_y) + int'(line_end_y)) / 2;
            emit = (ox > nx) ? (mid < oy) : (mid > oy);
         end else if (against_line(ox, oy, ny)) begin
            // first hit only arms the track
            if (wrong_way[d.track_id]) emit = 1;
            else wrong_way[d.track_id] = 1;
         end
         if (!emit) return;
         r.flagged_track = d.track_id;
         r.out_left = d.box_left;
         r.out_top = d.box_top;
         r.out_right = d.box_right;
         r.out_bottom = d.box_bottom;
         r.out_score = d.score;
         pending_flags = {pending_flags, r};
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP)
               $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_flag(rsp_type got);
         rsp_type want;
         if (pending_flags.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP)
               $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
            return;
         end
         want = pending_flags.pop_front();
         compare_field("flagged_track", want.flagged_track, got.flagged_track);
         compare_field("out_left", want.out_left, got.out_left);
         compare_field("out_top", want.out_top, got.out_top);
         compare_field("out_right", want.out_right, got.out_right);
         compare_field("out_bottom", want.out_bottom, got.out_bottom);
         compare_field("out_score", want.out_score, got.out_score);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   req_type               req_data = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_LINE_START_X;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   wrong_way_scoreboard sb;
   bit tx_idle;
   bit rx_idle;
   int rx_hold;

   track_wrong_way_detector dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // check the transaction taken at this edge, then choose pop for the next one
   always @(posedge clock) begin
      if (!reset && pop && !empty) sb.check_flag(rsp_data);
      if (rx_hold > 0) begin
         pop <= 1'b0;
         rx_hold--;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
         pop <= 1'b0;
         rx_hold = $urandom_range(1, 16) - 1;
      end else begin
         pop <= 1'b1;
      end
   end

   task automatic send_detection(input req_type d);
      push <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (full) @(posedge clock);
      sb.note_detection(d);
   endtask

   // hold off until every expected flag is out and the pipeline has emptied
   task automatic drain();
      push <= 1'b0;
      while (sb.pending_flags.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(index, value);
   endtask

   task automatic set_line(input logic [CSR_DATA_W-1:0] start_x, start_y, end_x, end_y,
                           input logic [CSR_DATA_W-1:0] mode);
      // indexes past the register list must be dropped
      for (int i = CSR_VERTICAL + 1; i < 2 ** CSR_IDX_W; i++)
         write_csr(CSR_IDX_W'(i), CSR_DATA_W'($urandom));
      write_csr(CSR_LINE_START_X, start_x);
      write_csr(CSR_LINE_START_Y, start_y);
      write_csr(CSR_LINE_END_X, end_x);
      write_csr(CSR_LINE_END_Y, end_y);
      write_csr(CSR_VERTICAL, mode);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_line(input bit rising);
      int x0, x1, y0, y1, t;
      x0 = $urandom_range(0, 640);
      x1 = $urandom_range(x0 + 1, 1280);
      y0 = $urandom_range(0, 360);
      y1 = $urandom_range(y0 + 1, 720);
      if (!rising) begin
         t = y0; y0 = y1; y1 = t;
      end
      if ($urandom_range(0, 1))
         set_line(CSR_DATA_W'(x1), CSR_DATA_W'(y1), CSR_DATA_W'(x0), CSR_DATA_W'(y0), 0);
      else
         set_line(CSR_DATA_W'(x0), CSR_DATA_W'(y0), CSR_DATA_W'(x1), CSR_DATA_W'(y1), 0);
   endtask

   function automatic req_type box_at(input int id, input int cx, input int cy,
                                      input int hw, input int hh);
      req_type d;
      d.track_id = ID_W'(id);
      d.box_left = X_W'((cx - hw < 0) ? 0 : cx - hw);
      d.box_right = X_W'((cx + hw > 2047) ? 2047 : cx + hw);
      d.box_top = Y_W'((cy - hh < 0) ? 0 : cy - hh);
      d.box_bottom = Y_W'((cy + hh > 1023) ? 1023 : cy + hh);
      d.score = SCORE_W'($urandom);
      d.track_lost = 1'b0;
      return d;
   endfunction

   task automatic run_directed();
      req_type d;
      // reset line has no y extent, so nothing is judged here
      d = '{track_id: '0, box_left: '0, box_top: '0, box_right: '0, box_bottom: '0,
            score: '0, track_lost: 1'b0};
      send_detection(d);
      d = '{track_id: '0, box_left: 11'd1280, box_top: 10'd720, box_right: 11'd1280,
            box_bottom: 10'd720, score: '1, track_lost: 1'b0};
      send_detection(d);
      d = '{track_id: '1, box_left: '1, box_top: '1, box_right: '1, box_bottom: '1,
            score: '1, track_lost: 1'b1};
      send_detection(d);
      send_detection(box_at(1023, 650, 350, 50, 50));
      send_detection(box_at(1023, 650, 370, 50, 50));
      drain();
      set_line(100, 100, 1100, 600, 0);
      for (int i = 0; i < 3; i++) send_detection(box_at(7, 300, 400 + 20 * i, 20, 20));
      for (int i = 0; i < 4; i++) send_detection(box_at(8, 300, 400 - 20 * i, 20, 20));
      // older centre exactly on the line
      send_detection(box_at(9, 300, 200, 20, 20));
      send_detection(box_at(9, 300, 220, 20, 20));
      drain();
      set_line(0, 100, 0, 600, 1);
      send_detection(box_at(10, 400, 300, 20, 20));
      send_detection(box_at(10, 380, 300, 20, 20));
      send_detection(box_at(11, 400, 400, 20, 20));
      send_detection(box_at(11, 380, 400, 20, 20));
      send_detection(box_at(12, 400, 300, 20, 20));
      send_detection(box_at(12, 420, 300, 20, 20));
      drain();
   endtask

   // mostly vehicles moving steadily across the frame, with some noise mixed in
   task automatic run_traffic(input int count);
      int              cx [TRAJECTORIES];
      int              cy [TRAJECTORIES];
      int              vx [TRAJECTORIES];
      int              vy [TRAJECTORIES];
      logic [ID_W-1:0] ids [TRAJECTORIES];
      req_type         d;
      int              k, n, roll;
      for (int i = 0; i < TRAJECTORIES; i++) cx[i] = -1000;
      n = 0;
      while (n < count) begin
         k = $urandom_range(0, TRAJECTORIES - 1);
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            d = $bits(req_type)'({$urandom, $urandom, $urandom});
         end else begin
            if (roll < 14) vy[k] = -vy[k];
            cx[k] += vx[k];
            cy[k] += vy[k];
            if (cx[k] < 10 || cx[k] > 1270 || cy[k] < 10 || cy[k] > 710) begin
               ids[k] = ID_W'($urandom);
               cx[k] = $urandom_range(20, 1260);
               cy[k] = $urandom_range(20, 700);
               vx[k] = int'($urandom_range(0, 50)) - 25;
               vy[k] = int'($urandom_range(1, 25)) * ($urandom_range(0, 1) ? 1 : -1);
            end
            d = box_at(int'(ids[k]), cx[k], cy[k], $urandom_range(0, 60),
                       $urandom_range(0, 40));
            d.box_right = d.box_right + X_W'($urandom_range(0, 1));
            d.track_lost = ($urandom_range(0, 19) == 0);
         end
         if (tx_idle && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         send_detection(d);
         if (!d.track_lost) n++;
      end
      drain();
   endtask

   initial begin
      sb = new();
      tx_idle = 1;
      rx_idle = 1;
      rx_hold = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      run_directed();

      random_line(1);
      run_traffic(350);
      random_line(0);
      rx_idle = 0;
      run_traffic(350);
      set_line(CSR_DATA_W'($urandom_range(0, 1280)), CSR_DATA_W'($urandom_range(0, 720)),
               CSR_DATA_W'($urandom_range(0, 1280)), CSR_DATA_W'($urandom_range(0, 720)), 1);
      tx_idle = 0;
      rx_idle = 1;
      run_traffic(250);
      set_line(1280, 0, 0, 720, 0);
      tx_idle = 1;
      run_traffic(250);
      // bit 10 of the y write and the upper mode bits fall outside the registers
      set_line(0, 11'h6D0, 1280, 720, 11'h7FF);
      tx_idle = 0;
      rx_idle = 0;
      run_traffic(100);
      set_line(1280, 0, 1280, 0, 1);
      run_traffic(100);
      set_line(200, 360, 1000, 360, 11'h7FE);
      tx_idle = 1;
      rx_idle = 1;
      run_traffic(75);
      set_line(640, 0, 640, 720, 0);
      run_traffic(75);
      random_line(1'($urandom_range(0, 1)));
      tx_idle = 0;
      rx_idle = 0;
      run_traffic(350);

      if (sb.mismatch_count == 0 && sb.pending_flags.size() == 0)
         $display("[track_wrong_way_detector] OK");
      else
         $display("[track_wrong_way_detector] ERROR");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("[track_wrong_way_detector] ERROR");
      $finish;
   end

endmodule
